/* hw/rtl/bst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg
// shared widths, item kinds and the command/status bundles of the tracker
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int KIND_W  = 2;
    localparam int TID_W   = 22;
    localparam int ADDR_W  = 48;
    localparam int CSLOT_W = 4;
    localparam int BCNT_W  = 12;
    localparam int HSUM_W  = 27;

    // 6 * address needs three more bits
    localparam int PROD_W  = ADDR_W + 3;
    localparam int HCNT_W  = 6;
    localparam int HASH_OFF = 6;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd2;

    typedef struct packed {
        logic load;
        logic sweep;
        logic hash_step;
        logic search_step;
        logic claim;
        logic set_full;
        logic rd;
        logic wr;
        logic cmp_issue;
        logic res_load;
    } bst_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic hash_last;
        logic search_hit;
        logic search_end;
        logic cmp_last;
    } bst_status_t;

endpackage
`default_nettype wire

/* hw/rtl/bst_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_if
// item and result channels of the tracker
// ----------------------------------------------------------------------------
interface bst_item_if;
    logic                       valid;
    logic                       ready;
    logic [bst_pkg::KIND_W-1:0]  kind;
    logic [bst_pkg::TID_W-1:0]   tid;
    logic [bst_pkg::ADDR_W-1:0]  address;
    logic [bst_pkg::CSLOT_W-1:0] first_slot;
    logic [bst_pkg::CSLOT_W-1:0] second_slot;

    modport source (output valid, kind, tid, address, first_slot, second_slot,
                    input ready);
    modport sink   (input valid, kind, tid, address, first_slot, second_slot,
                    output ready);
endinterface

interface bst_result_if;
    logic                       valid;
    logic                       ready;
    logic [bst_pkg::CSLOT_W-1:0] slot_used;
    logic                       table_full;
    logic [bst_pkg::BCNT_W-1:0]  shared_bits;
    logic [bst_pkg::BCNT_W-1:0]  bits_first;
    logic [bst_pkg::BCNT_W-1:0]  bits_second;
    logic [bst_pkg::HSUM_W-1:0]  hits_first;
    logic [bst_pkg::HSUM_W-1:0]  hits_second;
    logic [bst_pkg::HSUM_W-1:0]  shared_hits_first;
    logic [bst_pkg::HSUM_W-1:0]  shared_hits_second;
    logic                       any_shared;

    modport source (output valid, slot_used, table_full, shared_bits, bits_first,
                    bits_second, hits_first, hits_second, shared_hits_first,
                    shared_hits_second, any_shared,
                    input ready);
    modport sink   (input valid, slot_used, table_full, shared_bits, bits_first,
                    bits_second, hits_first, hits_second, shared_hits_first,
                    shared_hits_second, any_shared,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/per_thread_bloom_sharing_tracker_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_thread_bloom_sharing_tracker_core
// per-thread single-hash counting bloom filters with pairwise sharing compare
// ----------------------------------------------------------------------------
//  channel   role    beat contents
//  item      sink    kind, tid, address, first_slot, second_slot
//  result    source  slot_used, table_full, sharing counts and counter sums
//
//  insert: hashing of six 8-bit address chunks (msb first, each in an estimate
//    step and a correction step), a search over the slots in index order,
//    then a read and a write of the counter memory
//  compare: all FILTER_BITS filter bits, one filter bit of both slots per cycle
//    on the two read ports of the counter memory, then drain and result load
//  clear and reset: one memory entry per cycle over all 2**(clog2(SLOTS) +
//    clog2(FILTER_BITS)) entries (32768 by default), no item taken meanwhile
//  one item at a time; a finished result waits in the output register while
//    the next item is taken, and blocks only the following result
// ----------------------------------------------------------------------------
module per_thread_bloom_sharing_tracker_core #(
    parameter int SLOTS       = 16,
    parameter int FILTER_BITS = 2048,
    parameter int COUNT_WIDTH = 16
) (
    input  wire           clk,
    input  wire           rst_n,
    bst_item_if.sink      item,
    bst_result_if.source  result
);
    import bst_pkg::*;

    bst_cmd_t    cmd;
    bst_status_t st;

    // sequencer: owns handshakes and the result valid flag
    bst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_kind   (item.kind),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: slot table, counter memory and the result register
    bst_dp #(
        .SLOTS       (SLOTS),
        .FILTER_BITS (FILTER_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .kind               (item.kind),
        .tid                (item.tid),
        .address            (item.address),
        .first_slot         (item.first_slot),
        .second_slot        (item.second_slot),
        .slot_used          (result.slot_used),
        .table_full         (result.table_full),
        .shared_bits        (result.shared_bits),
        .bits_first         (result.bits_first),
        .bits_second        (result.bits_second),
        .hits_first         (result.hits_first),
        .hits_second        (result.hits_second),
        .shared_hits_first  (result.shared_hits_first),
        .shared_hits_second (result.shared_hits_second),
        .any_shared         (result.any_shared)
    );

`ifndef NO_ASSERTIONS
    // a beat taken leaves the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item taken twice in a row");

    // result valid only rises after the sequencer loads the result register
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.res_load))
        else $error("result valid without a load");

    // a dropped insert never names a slot
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.table_full |-> result.slot_used == '0)
        else $error("full insert reports a slot");

    // shared flag agrees with the shared count
    a_shared_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.any_shared == (result.shared_bits != '0)))
        else $error("shared flag mismatch");
`endif

endmodule
`default_nettype wire

/* hw/rtl/bst_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_dp
// slot table, counter memory, chunked hash unit and compare accumulators
// ----------------------------------------------------------------------------
module bst_dp #(
    parameter int SLOTS       = 16,
    parameter int FILTER_BITS = 2048,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  bst_pkg::bst_cmd_t              cmd,
    output bst_pkg::bst_status_t           st,
    input  wire [bst_pkg::KIND_W-1:0]      kind,
    input  wire [bst_pkg::TID_W-1:0]       tid,
    input  wire [bst_pkg::ADDR_W-1:0]      address,
    input  wire [bst_pkg::CSLOT_W-1:0]     first_slot,
    input  wire [bst_pkg::CSLOT_W-1:0]     second_slot,
    output logic [bst_pkg::CSLOT_W-1:0]    slot_used,
    output logic                           table_full,
    output logic [bst_pkg::BCNT_W-1:0]     shared_bits,
    output logic [bst_pkg::BCNT_W-1:0]     bits_first,
    output logic [bst_pkg::BCNT_W-1:0]     bits_second,
    output logic [bst_pkg::HSUM_W-1:0]     hits_first,
    output logic [bst_pkg::HSUM_W-1:0]     hits_second,
    output logic [bst_pkg::HSUM_W-1:0]     shared_hits_first,
    output logic [bst_pkg::HSUM_W-1:0]     shared_hits_second,
    output logic                           any_shared
);
    import bst_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW    = $clog2(FILTER_BITS);
    localparam int AW    = SW + HW;
    localparam int DEPTH = 1 << AW;
    localparam int CHUNK_W = 8;
    localparam int YW    = HW + CHUNK_W;
    // reciprocal of the filter size, scaled by 2**YW
    localparam logic [9:0]      INV    = 10'((1 << YW) / FILTER_BITS);
    localparam logic [YW-1:0]   MOD_Y  = YW'(FILTER_BITS);
    localparam logic [HW+2:0]   M1     = (HW+3)'(FILTER_BITS);
    localparam logic [HW+2:0]   M2     = (HW+3)'(2 * FILTER_BITS);
    localparam logic [HW+2:0]   M4     = (HW+3)'(4 * FILTER_BITS);
    localparam logic [HW+2:0]   OFF6   = (HW+3)'(FILTER_BITS - HASH_OFF);
    localparam logic [HW-1:0] K_LAST   = HW'(FILTER_BITS - 1);
    localparam logic [SW:0]   S_END    = (SW+1)'(SLOTS);
    localparam logic [HCNT_W-1:0] H_LAST = HCNT_W'(2 * (ADDR_W / CHUNK_W) - 1);

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rda_reg, rdb_reg;

    logic             slot_taken_reg [SLOTS];
    logic [TID_W-1:0] slot_thread_reg [SLOTS];

    logic [KIND_W-1:0]  kind_reg;
    logic [TID_W-1:0]   tid_reg;
    logic [ADDR_W-1:0]  ash_reg;
    logic [HCNT_W-1:0]  hcnt_reg;
    logic [HW-1:0]      rem_reg;
    logic [YW-1:0]      y_reg;
    logic [CHUNK_W-1:0] q_reg;
    logic [SW:0]        sidx_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      sw_cnt_reg;
    logic [HW-1:0]      kcnt_reg;
    logic [SW-1:0]      sa_reg, sb_reg;
    logic               va_reg, vb_reg;
    logic               acc_vld_reg;
    logic               full_reg;
    logic [SW-1:0]      hit_slot_reg;

    logic [BCNT_W-1:0]  na_reg, nb_reg, nsh_reg;
    logic [HSUM_W-1:0]  ha_reg, hb_reg, sha_reg, shb_reg;

    logic [YW-1:0]      y_now, qm, diff, rdiff;
    logic [YW+9:0]      qprod;
    logic [HW+2:0]      h0, h1, h2, h3;
    logic [HW-1:0]      hidx;
    logic [AW-1:0]      ra, rb;
    logic               ba, bb;
    logic [HSUM_W-1:0]  ca, cb;
    logic               is_ins, is_cmp;

    // address mod filter size, one 8-bit chunk at a time in two steps (msb first):
    // estimate the quotient by reciprocal, then one compare and subtract
    always_comb
    begin
        y_now = {rem_reg, ash_reg[ADDR_W-1 -: CHUNK_W]};
        qprod = (YW+10)'(y_now) * (YW+10)'(INV);
        qm    = YW'(q_reg) * MOD_Y;
        diff  = y_reg - qm;
        rdiff = (diff >= MOD_Y) ? diff - MOD_Y : diff;
    end

    // (6*rem - 6) mod filter size, the sum stays below seven times the size
    always_comb
    begin
        h0   = (HW+3)'({rem_reg, 2'b00}) + (HW+3)'({rem_reg, 1'b0}) + OFF6;
        h1   = (h0 >= M4) ? h0 - M4 : h0;
        h2   = (h1 >= M2) ? h1 - M2 : h1;
        h3   = (h2 >= M1) ? h2 - M1 : h2;
        hidx = h3[HW-1:0];
    end

    always_comb
    begin
        st.sweep_done = &sw_cnt_reg;
        st.hash_last  = (hcnt_reg == H_LAST);
        st.search_end = (sidx_reg == S_END);
        st.search_hit = 1'b0;
        if (sidx_reg < S_END)
        begin
            st.search_hit = !slot_taken_reg[sidx_reg[SW-1:0]] ||
                            (slot_thread_reg[sidx_reg[SW-1:0]] == tid_reg);
        end
        st.cmp_last   = (kcnt_reg == K_LAST);
    end

    assign ra = cmd.cmp_issue ? {sa_reg, kcnt_reg} : addr_reg;
    assign rb = {sb_reg, kcnt_reg};

    // counter memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            mem[sw_cnt_reg] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr_reg] <= (&rda_reg) ? rda_reg : rda_reg + 1'b1;
        end
        if (cmd.rd || cmd.cmp_issue)
        begin
            rda_reg <= mem[ra];
        end
        if (cmd.cmp_issue)
        begin
            rdb_reg <= mem[rb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cnt_reg  <= '0;
            acc_vld_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_taken_reg[i] <= 1'b0;
            end
        end
        else
        begin
            acc_vld_reg <= cmd.cmp_issue;
            if (cmd.sweep)
            begin
                sw_cnt_reg <= sw_cnt_reg + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_taken_reg[i] <= 1'b0;
                end
            end
            if (cmd.claim)
            begin
                slot_taken_reg[sidx_reg[SW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_thread_reg[i] <= '0;
            end
        end
        if (cmd.claim)
        begin
            slot_thread_reg[sidx_reg[SW-1:0]] <= tid_reg;
            addr_reg     <= {sidx_reg[SW-1:0], hidx};
            hit_slot_reg <= sidx_reg[SW-1:0];
        end
        if (cmd.load)
        begin
            kind_reg <= kind;
            tid_reg  <= tid;
            ash_reg  <= address;
            hcnt_reg <= '0;
            rem_reg  <= '0;
            sidx_reg <= '0;
            kcnt_reg <= '0;
            full_reg <= 1'b0;
            sa_reg   <= SW'(first_slot);
            sb_reg   <= SW'(second_slot);
            va_reg   <= ({1'b0, first_slot} < (CSLOT_W+1)'(SLOTS > 16 ? 16 : SLOTS));
            vb_reg   <= ({1'b0, second_slot} < (CSLOT_W+1)'(SLOTS > 16 ? 16 : SLOTS));
            na_reg   <= '0;
            nb_reg   <= '0;
            nsh_reg  <= '0;
            ha_reg   <= '0;
            hb_reg   <= '0;
            sha_reg  <= '0;
            shb_reg  <= '0;
        end
        if (cmd.hash_step)
        begin
            hcnt_reg <= hcnt_reg + 1'b1;
            if (!hcnt_reg[0])
            begin
                y_reg <= y_now;
                q_reg <= qprod[YW +: CHUNK_W];
            end
            else
            begin
                rem_reg <= rdiff[HW-1:0];
                ash_reg <= ash_reg << CHUNK_W;
            end
        end
        if (cmd.search_step)
        begin
            sidx_reg <= sidx_reg + 1'b1;
        end
        if (cmd.set_full)
        begin
            full_reg <= 1'b1;
        end
        if (cmd.cmp_issue)
        begin
            kcnt_reg <= kcnt_reg + 1'b1;
        end
        if (acc_vld_reg)
        begin
            if (ba)
            begin
                na_reg <= na_reg + 1'b1;
                ha_reg <= ha_reg + ca;
            end
            if (bb)
            begin
                nb_reg <= nb_reg + 1'b1;
                hb_reg <= hb_reg + cb;
            end
            if (ba && bb)
            begin
                nsh_reg <= nsh_reg + 1'b1;
                sha_reg <= sha_reg + ca;
                shb_reg <= shb_reg + cb;
            end
        end
    end

    // a bit is set exactly when its counter is nonzero
    always_comb
    begin
        ba = va_reg && (rda_reg != '0);
        bb = vb_reg && (rdb_reg != '0);
        ca = HSUM_W'(rda_reg);
        cb = HSUM_W'(rdb_reg);
    end

    assign is_ins = (kind_reg == KIND_INSERT);
    assign is_cmp = (kind_reg == KIND_COMPARE);

    // fields the item kind does not define read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            slot_used          <= (is_ins && !full_reg) ? CSLOT_W'(hit_slot_reg) : '0;
            table_full         <= is_ins && full_reg;
            shared_bits        <= is_cmp ? nsh_reg : '0;
            bits_first         <= is_cmp ? na_reg : '0;
            bits_second        <= is_cmp ? nb_reg : '0;
            hits_first         <= is_cmp ? ha_reg : '0;
            hits_second        <= is_cmp ? hb_reg : '0;
            shared_hits_first  <= is_cmp ? sha_reg : '0;
            shared_hits_second <= is_cmp ? shb_reg : '0;
            any_shared         <= is_cmp && (nsh_reg != '0);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_ctrl
// sequencer: sweep, hash, slot search, counter update, compare walk, result
// ----------------------------------------------------------------------------
module bst_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [bst_pkg::KIND_W-1:0]    in_kind,
    output logic                         out_valid,
    input  wire                          out_ready,
    input  bst_pkg::bst_status_t         st,
    output bst_pkg::bst_cmd_t            cmd
);
    import bst_pkg::*;

    localparam logic [3:0] ST_SWEEP  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_HASH   = 4'd2;
    localparam logic [3:0] ST_SEARCH = 4'd3;
    localparam logic [3:0] ST_RD     = 4'd4;
    localparam logic [3:0] ST_WR     = 4'd5;
    localparam logic [3:0] ST_CMP    = 4'd6;
    localparam logic [3:0] ST_DRAIN  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (st.sweep_done)
                begin
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_kind)
                        KIND_CLEAR:
                        begin
                            pend_next  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        KIND_INSERT:  state_next = ST_HASH;
                        KIND_COMPARE: state_next = ST_CMP;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (st.hash_last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (st.search_end)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (st.search_hit)
                begin
                    cmd.claim  = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_CMP:
            begin
                cmd.cmp_issue = 1'b1;
                if (st.cmp_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* test/per_thread_bloom_sharing_tracker_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_thread_bloom_sharing_tracker_core_test
// drives clear, insert, compare and unused-kind beats into the tracker and
// checks each result beat against a local model of the per-thread filter slots
// ----------------------------------------------------------------------------
module per_thread_bloom_sharing_tracker_core_test;

    import bst_pkg::*;

    localparam int SLOT_CNT  = 16;
    localparam int FBITS     = 2048;
    localparam int HIT_W     = 16;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 6000000;
    // a clear sweeps 32768 entries, so the tail wait covers one of those
    localparam int TAIL_CYCLES = 40000;

    typedef struct packed {
        logic [CSLOT_W-1:0] slot_used;
        logic               table_full;
        logic [BCNT_W-1:0]  shared_bits;
        logic [BCNT_W-1:0]  bits_first;
        logic [BCNT_W-1:0]  bits_second;
        logic [HSUM_W-1:0]  hits_first;
        logic [HSUM_W-1:0]  hits_second;
        logic [HSUM_W-1:0]  shared_hits_first;
        logic [HSUM_W-1:0]  shared_hits_second;
        logic               any_shared;
    } tracker_result_t;

    logic clk;
    logic rst_n;

    bst_item_if   item_ch ();
    bst_result_if result_ch ();

    per_thread_bloom_sharing_tracker_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // ------------------------------------------------------------------------
    // local copy of the slot table and the filters
    // ------------------------------------------------------------------------
    logic              owned      [SLOT_CNT];
    logic [TID_W-1:0]  owner_tid  [SLOT_CNT];
    logic              presence   [SLOT_CNT][FBITS];
    logic [HIT_W-1:0]  hit_cnt    [SLOT_CNT][FBITS];

    tracker_result_t pending_results[$];

    int  mismatches = 0;
    int  burst_left;
    longint cycle_cnt = 0;

    function automatic void wipe_tracker();
        for (int s = 0; s < SLOT_CNT; s++)
        begin
            owned[s]     = 1'b0;
            owner_tid[s] = '0;
            for (int b = 0; b < FBITS; b++)
            begin
                presence[s][b] = 1'b0;
                hit_cnt[s][b]  = '0;
            end
        end
    endfunction

    // (6*addr - 6) mod FBITS; FBITS is a power of two, so wrapping is exact
    function automatic logic [10:0] bloom_index(logic [ADDR_W-1:0] addr);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(addr) * PROD_W'(6) - PROD_W'(HASH_OFF);
        return prod[10:0];
    endfunction

    function automatic tracker_result_t track_item(logic [KIND_W-1:0] kind,
                                                   logic [TID_W-1:0] tid,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [CSLOT_W-1:0] sa,
                                                   logic [CSLOT_W-1:0] sb);
        tracker_result_t r;
        logic [10:0] h;
        logic found;
        r = '0;
        found = 1'b0;
        if (kind == KIND_CLEAR)
            wipe_tracker();
        else if (kind == KIND_INSERT)
        begin
            h = bloom_index(addr);
            for (int s = 0; s < SLOT_CNT; s++)
            begin
                if (!found && (!owned[s] || owner_tid[s] == tid))
                begin
                    found = 1'b1;
                    owned[s] = 1'b1;
                    owner_tid[s] = tid;
                    presence[s][h] = 1'b1;
                    // saturating hit counter
                    if (hit_cnt[s][h] != '1)
                        hit_cnt[s][h] = hit_cnt[s][h] + 1'b1;
                    r.slot_used = CSLOT_W'(s);
                end
            end
            r.table_full = !found;
        end
        else if (kind == KIND_COMPARE)
        begin
            for (int b = 0; b < FBITS; b++)
            begin
                if (presence[sa][b])
                begin
                    r.bits_first = r.bits_first + 1'b1;
                    r.hits_first = r.hits_first + HSUM_W'(hit_cnt[sa][b]);
                end
                if (presence[sb][b])
                begin
                    r.bits_second = r.bits_second + 1'b1;
                    r.hits_second = r.hits_second + HSUM_W'(hit_cnt[sb][b]);
                end
                if (presence[sa][b] && presence[sb][b])
                begin
                    r.shared_bits = r.shared_bits + 1'b1;
                    r.shared_hits_first  = r.shared_hits_first + HSUM_W'(hit_cnt[sa][b]);
                    r.shared_hits_second = r.shared_hits_second + HSUM_W'(hit_cnt[sb][b]);
                end
            end
            r.any_shared = (r.shared_bits != '0);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("per_thread_bloom_sharing_tracker_core_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int quiet_left = 0;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (quiet_left > 0)
                quiet_left <= quiet_left - 1;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: stall_left <= $urandom_range(1, 40);
                    3:       quiet_left <= $urandom_range(50, 300);
                    default: ;
                endcase
            end
        end
    end

    // every accepted result beat is popped against the oldest expectation
    always @(posedge clk)
    begin
        tracker_result_t got;
        tracker_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.slot_used, result_ch.table_full, result_ch.shared_bits,
                    result_ch.bits_first, result_ch.bits_second, result_ch.hits_first,
                    result_ch.hits_second, result_ch.shared_hits_first,
                    result_ch.shared_hits_second, result_ch.any_shared};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch at cycle %0d", cycle_cnt);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------------
    task automatic send_item(logic [KIND_W-1:0] kind, logic [TID_W-1:0] tid,
                             logic [ADDR_W-1:0] addr, logic [CSLOT_W-1:0] sa,
                             logic [CSLOT_W-1:0] sb);
        item_ch.kind        <= kind;
        item_ch.tid         <= tid;
        item_ch.address     <= addr;
        item_ch.first_slot  <= sa;
        item_ch.second_slot <= sb;
        item_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_results.push_back(track_item(kind, tid, addr, sa, sb));
        burst_left--;
        // valid drops only when a real gap follows, never for an empty gap
        if (burst_left <= 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 8);
        end
    endtask

    // hold the item side until every expected beat has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_field_extremes();
        send_item(KIND_INSERT, '0, '0, '0, '0);                 // wraps below zero
        send_item(KIND_INSERT, '0, 48'd1, '0, '0);              // hashes to bit zero
        send_item(KIND_INSERT, '0, 48'd1, '1, '1);              // same bit again
        send_item(KIND_INSERT, '1, '1, '0, '0);
        send_item(KIND_INSERT, 22'h2AAAAA, 48'h5555_5555_5555, '0, '0);
        send_item(KIND_INSERT, 22'h155555, 48'hAAAA_AAAA_AAAA, '0, '0);
        send_item(KIND_INSERT, 22'h155555, 48'd1, '0, '0);
        send_item(KIND_COMPARE, '1, '1, 4'd0, 4'd1);
        send_item(KIND_COMPARE, '0, '0, 4'd0, 4'd0);            // slot against itself
        send_item(KIND_COMPARE, '0, '0, 4'd3, 4'd0);            // shared bit present
        send_item(KIND_COMPARE, '0, '0, 4'd15, 4'd14);          // free slots
        send_item(KIND_UNUSED, '1, '1, '1, '1);                 // ignored kind
        send_item(KIND_COMPARE, '0, '0, 4'd1, 4'd3);
    endtask

    task automatic test_full_table();
        send_item(KIND_CLEAR, '1, '1, '1, '1);
        for (int t = 0; t < SLOT_CNT; t++)
            send_item(KIND_INSERT, TID_W'(t * 7 + 1), ADDR_W'(t), '0, '0);
        send_item(KIND_INSERT, 22'h3FFFF0, 48'd99, '0, '0);     // no slot left
        send_item(KIND_INSERT, 22'd8, 48'd5, '0, '0);           // owner still found
        send_item(KIND_COMPARE, '0, '0, 4'd15, 4'd1);
    endtask

    task automatic test_idle_refill();
        drain_results();
        send_item(KIND_INSERT, 22'd8, 48'd77, '0, '0);
        send_item(KIND_COMPARE, '0, '0, 4'd1, 4'd1);
    endtask

    task automatic test_random_traffic(int n_items);
        logic [TID_W-1:0]  tid_pool  [20];
        logic [ADDR_W-1:0] addr_pool [8];
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            // a new working set every few hundred beats
            if (i % 300 == 0)
            begin
                foreach (tid_pool[k])
                    tid_pool[k] = TID_W'($urandom);
                foreach (addr_pool[k])
                    addr_pool[k] = rand_addr();
            end
            pick = $urandom_range(0, 999);
            if (i % 450 == 449)
                send_item(KIND_CLEAR, TID_W'($urandom), rand_addr(),
                          CSLOT_W'($urandom), CSLOT_W'($urandom));
            else if (pick < 70)
                send_item(KIND_COMPARE, TID_W'($urandom), rand_addr(),
                          CSLOT_W'($urandom), CSLOT_W'($urandom));
            else if (pick < 80)
                send_item(KIND_UNUSED, TID_W'($urandom), rand_addr(),
                          CSLOT_W'($urandom), CSLOT_W'($urandom));
            else if (pick < 180)
                send_item(KIND_INSERT, TID_W'($urandom), rand_addr(),
                          CSLOT_W'($urandom), CSLOT_W'($urandom));
            else
                // pooled threads fill the table, pooled addresses make overlap
                send_item(KIND_INSERT, tid_pool[$urandom_range(0, 19)],
                          ($urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)]
                                                : rand_addr()),
                          CSLOT_W'($urandom), CSLOT_W'($urandom));
        end
    endtask

    initial
    begin
        int tail;
        rst_n = 1'b0;
        burst_left = 4;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= '0;
        item_ch.tid         <= '0;
        item_ch.address     <= '0;
        item_ch.first_slot  <= '0;
        item_ch.second_slot <= '0;
        wipe_tracker();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_full_table();
        test_idle_refill();
        test_random_traffic(1860);

        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < TAIL_CYCLES)
        begin
            @(posedge clk);
            tail++;
        end
        if (mismatches == 0 && pending_results.size() == 0)
            $display("per_thread_bloom_sharing_tracker_core_test: clean");
        else
            $display("per_thread_bloom_sharing_tracker_core_test: errors");
        $finish;
    end

endmodule
